### sv/mcft_pkg.sv
// Shared types, codes and the key transposition function of the chord-follow transposer.
package mcft_pkg;

  localparam int CHANNELS = 16;
  localparam int CH_W     = $clog2(CHANNELS);

  localparam logic [7:0] NOTE_ON  = 8'd144;
  localparam logic [7:0] NOTE_OFF = 8'd128;
  localparam logic [CH_W-1:0] DRUM_CH_A = CH_W'(9);
  localparam logic [CH_W-1:0] DRUM_CH_B = CH_W'(10);
  localparam logic signed [3:0] ROOT_KEEP = -4'sd6;

  typedef enum logic [1:0] {
    CMD_EVENT = 2'd0,
    CMD_CHORD = 2'd1,
    CMD_TICK  = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_FWD    = 2'd0,
    KIND_OFF    = 2'd1,
    KIND_RESEND = 2'd2
  } kind_t;

  typedef struct packed {
    logic [1:0]        command;
    logic [CH_W-1:0]   in_channel;
    logic [7:0]        in_type;
    logic [6:0]        in_data1;
    logic [6:0]        in_data2;
    logic signed [3:0] chord_root;
    logic              chord_minor;
  } req_t;

  typedef struct packed {
    logic [1:0]      out_kind;
    logic [CH_W-1:0] out_channel;
    logic [7:0]      out_type;
    logic [6:0]      out_data1;
    logic [6:0]      out_data2;
    logic            out_last;
  } rsp_t;

  // one held-note entry: key and velocity
  typedef struct packed {
    logic [6:0] key;
    logic [6:0] vel;
  } held_t;

  typedef struct packed {
    logic            we;
    logic [CH_W-1:0] waddr;
    held_t           wdata;
    logic            re;
    logic [CH_W-1:0] raddr;
  } ram_ctl_t;

  // key + root + degree fix-up, clamped to 0..127
  function automatic logic [6:0] transpose(input logic [6:0] key,
                                           input logic signed [3:0] root,
                                           input logic chord_minor,
                                           input logic style_minor);
    logic [12:0]       prod;
    logic [3:0]        quot;
    logic [6:0]        deg;
    logic signed [8:0] adj;
    logic signed [8:0] sum;
    logic [6:0]        res;
    // key / 12 as (key * 43) >> 9, exact for 7-bit keys
    prod = 13'(key) * 13'd43;
    quot = prod[12:9];
    deg  = key - 7'(quot) * 7'd12;
    adj  = 9'sd0;
    if (!style_minor && chord_minor) begin
      if (deg == 7'd4 || deg == 7'd9 || deg == 7'd11) adj = -9'sd1;
    end else if (style_minor && !chord_minor) begin
      if (deg == 7'd3 || deg == 7'd8 || deg == 7'd10) adj = 9'sd1;
    end
    sum = $signed({2'b00, key}) + 9'(root) + adj;
    if (sum < 0)            res = 7'd0;
    else if (sum > 9'sd127) res = 7'd127;
    else                    res = sum[6:0];
    return res;
  endfunction

endpackage

### sv/midi_chord_follow_transposer_unit.sv
// Top level of the chord-follow MIDI transposer: control sequencer and config port.
// An event's result is valid the cycle after its request is taken.
// Tick with a change pending: all-notes-off the cycle after the request, then each held
// note is re-sent in turn (result drain, memory read, output load).
// One request at a time; the next is taken once the last result has been taken.
// Reset (rst, synchronous): no held notes, root 0, major chord, no change pending.
module midi_chord_follow_transposer_unit (
  input  logic             clk,
  input  logic             rst,
  // request channel
  input  logic             req_valid,
  output logic             req_ready,
  input  mcft_pkg::req_t   req,
  // result channel
  output logic             rsp_valid,
  input  logic             rsp_ready,
  output mcft_pkg::rsp_t   rsp,
  // config port
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [1:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,  // waiting for a request
    ST_SCAN = 3'b010,  // pick the next held channel, start its read
    ST_RD   = 3'b100   // read data back, load the result register
  } state_t;

  localparam int CH = mcft_pkg::CHANNELS;
  localparam int CW = mcft_pkg::CH_W;

  state_t state, state_next;

  // config and chord state
  logic              style_minor;
  logic signed [3:0] cur_root;
  logic              cur_minor;
  logic              pending;

  // per-channel held flags live in flops; key/velocity in the memory
  logic [CH-1:0] held_valid;
  logic [CH-1:0] rem;       // channels still to re-send on this tick
  logic [CW-1:0] rd_ch;     // channel whose read is in flight

  mcft_pkg::ram_ctl_t ram_ctl;
  mcft_pkg::held_t    ram_rdata;

  logic          accept;
  logic          tracked;
  logic          is_note;
  logic [CW-1:0] pick;
  logic [CH-1:0] pick_mask;

  // APB: a single register, every word address maps onto it
  assign pready = 1'b1;
  assign prdata = {31'd0, style_minor};

  always_ff @(posedge clk) begin
    if (rst) begin
      style_minor <= 1'b0;
    end else if (psel && penable && pwrite) begin
      style_minor <= pwdata[0];
    end
  end

  assign req_ready = (state == ST_IDLE) && !rsp_valid;
  assign accept    = req_valid && req_ready;

  assign tracked = (req.in_channel != mcft_pkg::DRUM_CH_A) &&
                   (req.in_channel != mcft_pkg::DRUM_CH_B);
  assign is_note = (req.in_type == mcft_pkg::NOTE_ON) ||
                   (req.in_type == mcft_pkg::NOTE_OFF);

  // lowest pending channel; 16-wide priority pick
  always_comb begin
    pick = '0;
    for (int i = CH - 1; i >= 0; i--) begin
      if (rem[i]) pick = CW'(i);
    end
    pick_mask = '0;
    pick_mask[pick] = 1'b1;
  end

  // memory control: writes only from IDLE, reads only from SCAN, never overlap
  always_comb begin
    ram_ctl       = '0;
    ram_ctl.waddr = req.in_channel;
    ram_ctl.wdata = '{key: req.in_data1, vel: req.in_data2};
    ram_ctl.raddr = pick;
    ram_ctl.we    = accept && (mcft_pkg::cmd_t'(req.command) == mcft_pkg::CMD_EVENT) &&
                    tracked && (req.in_type == mcft_pkg::NOTE_ON);
    ram_ctl.re    = (state == ST_SCAN) && !rsp_valid;
  end

  mcft_held_ram u_ram (
    .clk   (clk),
    .ctl   (ram_ctl),
    .rdata (ram_rdata)
  );

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && (mcft_pkg::cmd_t'(req.command) == mcft_pkg::CMD_TICK) &&
            pending && (held_valid != '0)) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!rsp_valid) state_next = ST_RD;
      end
      ST_RD: begin
        state_next = (rem != '0) ? ST_SCAN : ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      cur_root   <= 4'sd0;
      cur_minor  <= 1'b0;
      pending    <= 1'b0;
      held_valid <= '0;
      rem        <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (rsp_valid && rsp_ready) rsp_valid <= 1'b0;

      if (accept) begin
        unique case (mcft_pkg::cmd_t'(req.command))
          mcft_pkg::CMD_EVENT: begin
            if (tracked && req.in_type == mcft_pkg::NOTE_ON) begin
              held_valid[req.in_channel] <= 1'b1;
            end else if (tracked && req.in_type == mcft_pkg::NOTE_OFF) begin
              held_valid[req.in_channel] <= 1'b0;
            end
            rsp_valid <= 1'b1;
          end
          mcft_pkg::CMD_CHORD: begin
            // root of -6 means keep the current chord
            if (req.chord_root != mcft_pkg::ROOT_KEEP) begin
              cur_root  <= req.chord_root;
              cur_minor <= req.chord_minor;
              pending   <= 1'b1;
            end
          end
          mcft_pkg::CMD_TICK: begin
            if (pending) begin
              pending   <= 1'b0;
              rem       <= held_valid;
              rsp_valid <= 1'b1;
            end
          end
          mcft_pkg::CMD_CLEAR: begin
            held_valid <= '0;
            rsp_valid  <= 1'b1;
          end
          default: ;
        endcase
      end

      if (state == ST_SCAN && !rsp_valid) begin
        rem <= rem & ~pick_mask;
      end
      if (state == ST_RD) begin
        rsp_valid <= 1'b1;
      end
    end
  end

  // result payload and read bookkeeping
  always_ff @(posedge clk) begin
    if (state == ST_SCAN && !rsp_valid) begin
      rd_ch <= pick;
    end
    if (accept) begin
      if (mcft_pkg::cmd_t'(req.command) == mcft_pkg::CMD_EVENT) begin
        rsp.out_kind    <= mcft_pkg::KIND_FWD;
        rsp.out_channel <= req.in_channel;
        rsp.out_type    <= req.in_type;
        rsp.out_data1   <= (is_note && tracked) ?
                           mcft_pkg::transpose(req.in_data1, cur_root, cur_minor,
                                               style_minor) : req.in_data1;
        rsp.out_data2   <= req.in_data2;
        rsp.out_last    <= 1'b1;
      end else begin
        // all-notes-off; last unless a tick has notes to re-send
        rsp.out_kind    <= mcft_pkg::KIND_OFF;
        rsp.out_channel <= '0;
        rsp.out_type    <= '0;
        rsp.out_data1   <= '0;
        rsp.out_data2   <= '0;
        rsp.out_last    <= (mcft_pkg::cmd_t'(req.command) == mcft_pkg::CMD_CLEAR) ||
                           (held_valid == '0);
      end
    end else if (state == ST_RD) begin
      rsp.out_kind    <= mcft_pkg::KIND_RESEND;
      rsp.out_channel <= rd_ch;
      rsp.out_type    <= mcft_pkg::NOTE_ON;
      rsp.out_data1   <= mcft_pkg::transpose(ram_rdata.key, cur_root, cur_minor,
                                             style_minor);
      rsp.out_data2   <= ram_rdata.vel;
      rsp.out_last    <= (rem == '0);
    end
  end

  // checks
  a_drum_untracked: assert property (@(posedge clk) disable iff (rst)
    !held_valid[mcft_pkg::DRUM_CH_A] && !held_valid[mcft_pkg::DRUM_CH_B])
    else $error("drum channel marked as held");

  a_read_then_load: assert property (@(posedge clk) disable iff (rst)
    ram_ctl.re |=> (state == ST_RD) && !rsp_valid)
    else $error("memory read not followed by result load");

  a_last_ends_request: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_ready && rsp.out_last) |=> (state == ST_IDLE))
    else $error("last result taken while sequence still active");

  a_resend_note_on: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.out_kind == mcft_pkg::KIND_RESEND) |->
      (rsp.out_type == mcft_pkg::NOTE_ON))
    else $error("re-sent note is not a note on");

endmodule

### sv/mcft_held_ram.sv
// Held-note memory: one write port, one registered read port.
module mcft_held_ram (
  input  logic              clk,
  input  mcft_pkg::ram_ctl_t ctl,
  output mcft_pkg::held_t   rdata
);

  mcft_pkg::held_t mem [mcft_pkg::CHANNELS];

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[ctl.waddr] <= ctl.wdata;
    end
    if (ctl.re) begin
      rdata <= mem[ctl.raddr];
    end
  end

endmodule

### sim/mcft_checker.sv
// Request/result monitor of the chord-follow transposer: predicts the results and compares them.
`timescale 1ns / 100ps

module mcft_checker #(
  parameter logic [1:0] STYLE_ADDR = 2'd0
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  input  logic            req_ready,
  input  mcft_pkg::req_t  req,
  input  logic            rsp_valid,
  input  logic            rsp_ready,
  input  mcft_pkg::rsp_t  rsp,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [1:0]      paddr,
  input  logic [31:0]     pwdata,
  input  logic            pready,
  output int              errors,
  output int              pending,
  output int              requests_seen,
  output int              results_seen
);
  import mcft_pkg::*;

  // predicted chord-follow state
  logic [CHANNELS-1:0] held_on;
  held_t               held_q [CHANNELS];
  logic signed [3:0]   root_q;
  logic                chord_minor_q;
  logic                change_pending_q;
  logic                style_minor_q;

  rsp_t want_q [$];
  int   err_n;
  int   req_n;
  int   rsp_n;

  function automatic logic [6:0] shift_key(logic [6:0] key);
    int deg;
    int adj;
    int sum;
    deg = int'(key) % 12;
    adj = 0;
    if (!style_minor_q && chord_minor_q) begin
      if (deg == 4 || deg == 9 || deg == 11) adj = -1;
    end else if (style_minor_q && !chord_minor_q) begin
      if (deg == 3 || deg == 8 || deg == 10) adj = 1;
    end
    sum = int'(key) + int'(root_q) + adj;
    if (sum < 0) sum = 0;
    if (sum > 127) sum = 127;
    return 7'(sum);
  endfunction

  function automatic logic follows_chord(logic [CH_W-1:0] ch);
    return ch != DRUM_CH_A && ch != DRUM_CH_B;
  endfunction

  function automatic void add_result(kind_t kind, logic [CH_W-1:0] ch, logic [7:0] typ,
                                     logic [6:0] d1, logic [6:0] d2);
    rsp_t r;
    r.out_kind    = kind;
    r.out_channel = ch;
    r.out_type    = typ;
    r.out_data1   = d1;
    r.out_data2   = d2;
    r.out_last    = 1'b0;
    want_q.push_back(r);
  endfunction

  function automatic void apply_request(req_t r);
    int   before_n;
    rsp_t tail;
    logic is_note;
    before_n = want_q.size();
    case (r.command)
      CMD_EVENT: begin
        is_note = (r.in_type == NOTE_ON) || (r.in_type == NOTE_OFF);
        if (follows_chord(r.in_channel)) begin
          if (r.in_type == NOTE_ON) begin
            held_on[r.in_channel]    = 1'b1;
            held_q[r.in_channel].key = r.in_data1;
            held_q[r.in_channel].vel = r.in_data2;
          end else if (r.in_type == NOTE_OFF) begin
            held_on[r.in_channel] = 1'b0;
          end
        end
        add_result(KIND_FWD, r.in_channel, r.in_type,
                   (is_note && follows_chord(r.in_channel)) ? shift_key(r.in_data1)
                                                            : r.in_data1,
                   r.in_data2);
      end
      CMD_CHORD: begin
        // keep-chord code leaves everything alone
        if (r.chord_root != ROOT_KEEP) begin
          root_q           = r.chord_root;
          chord_minor_q    = r.chord_minor;
          change_pending_q = 1'b1;
        end
      end
      CMD_TICK: begin
        if (change_pending_q) begin
          change_pending_q = 1'b0;
          add_result(KIND_OFF, '0, '0, '0, '0);
          for (int ch = 0; ch < CHANNELS; ch++) begin
            if (follows_chord(CH_W'(ch)) && held_on[ch])
              add_result(KIND_RESEND, CH_W'(ch), NOTE_ON, shift_key(held_q[ch].key),
                         held_q[ch].vel);
          end
        end
      end
      default: begin
        held_on = '0;
        add_result(KIND_OFF, '0, '0, '0, '0);
      end
    endcase
    // flag the final result of this request
    if (want_q.size() > before_n) begin
      tail = want_q.pop_back();
      tail.out_last = 1'b1;
      want_q.push_back(tail);
    end
  endfunction

  function automatic void compare_result(rsp_t got);
    rsp_t want;
    if (want_q.size() == 0) begin
      $error("unexpected result: kind %0d ch %0d type %0d d1 %0d d2 %0d last %0d",
             got.out_kind, got.out_channel, got.out_type, got.out_data1,
             got.out_data2, got.out_last);
      err_n++;
      return;
    end
    want = want_q.pop_front();
    if (got.out_kind !== want.out_kind) begin
      $error("out_kind: expected %0d, got %0d", want.out_kind, got.out_kind);
      err_n++;
    end
    if (got.out_channel !== want.out_channel) begin
      $error("out_channel: expected %0d, got %0d", want.out_channel, got.out_channel);
      err_n++;
    end
    if (got.out_type !== want.out_type) begin
      $error("out_type: expected %0d, got %0d", want.out_type, got.out_type);
      err_n++;
    end
    if (got.out_data1 !== want.out_data1) begin
      $error("out_data1: expected %0d, got %0d", want.out_data1, got.out_data1);
      err_n++;
    end
    if (got.out_data2 !== want.out_data2) begin
      $error("out_data2: expected %0d, got %0d", want.out_data2, got.out_data2);
      err_n++;
    end
    if (got.out_last !== want.out_last) begin
      $error("out_last: expected %0d, got %0d", want.out_last, got.out_last);
      err_n++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      held_on          = '0;
      root_q           = '0;
      chord_minor_q    = 1'b0;
      change_pending_q = 1'b0;
      style_minor_q    = 1'b0;
      want_q.delete();
      err_n = 0;
      req_n = 0;
      rsp_n = 0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        compare_result(rsp);
        rsp_n++;
      end
      if (req_valid && req_ready) begin
        apply_request(req);
        req_n++;
      end
      if (psel && penable && pwrite && pready && paddr == STYLE_ADDR)
        style_minor_q = pwdata[0];
    end
    errors        <= err_n;
    pending       <= want_q.size();
    requests_seen <= req_n;
    results_seen  <= rsp_n;
  end

endmodule

### sim/tb_midi_chord_follow_transposer_unit.sv
// Testbench top of the chord-follow transposer: stimulus, config writes and verdict.
`timescale 1ns / 100ps

module tb_midi_chord_follow_transposer_unit;
  import mcft_pkg::*;

  localparam logic [1:0] STYLE_ADDR  = 2'd0;     // style_minor register
  localparam logic [7:0] CTRL_CHANGE = 8'hB0;    // a non-note status type
  localparam int RANDOM_PER_PHASE    = 128;
  localparam int SETTLE_CYCLES       = 40;
  localparam int CYCLE_LIMIT         = 400000;

  logic        clk = 1'b0;
  logic        rst;
  logic        req_valid;
  logic        req_ready;
  req_t        req;
  logic        rsp_valid;
  logic        rsp_ready = 1'b0;
  rsp_t        rsp;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [1:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int errors;
  int pending;
  int requests_seen;
  int results_seen;
  int cycles = 0;
  int snd_idle;   // percent of cycles the request side holds back
  int rcv_idle;   // percent of cycles the result side stalls

  always #2 clk = ~clk;

  midi_chord_follow_transposer_unit dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  mcft_checker #(.STYLE_ADDR(STYLE_ADDR)) chk (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req_valid),
    .req_ready     (req_ready),
    .req           (req),
    .rsp_valid     (rsp_valid),
    .rsp_ready     (rsp_ready),
    .rsp           (rsp),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .pready        (pready),
    .errors        (errors),
    .pending       (pending),
    .requests_seen (requests_seen),
    .results_seen  (results_seen)
  );

  // result-side backpressure, redrawn every cycle
  always @(posedge clk) rsp_ready <= ($urandom_range(99) >= rcv_idle);

  // watchdog: a hung handshake ends the run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic req_t make_req(cmd_t cmd, logic [3:0] ch, logic [7:0] typ,
                                    logic [6:0] d1, logic [6:0] d2,
                                    logic signed [3:0] root, logic minor);
    req_t r;
    r.command     = cmd;
    r.in_channel  = ch;
    r.in_type     = typ;
    r.in_data1    = d1;
    r.in_data2    = d2;
    r.chord_root  = root;
    r.chord_minor = minor;
    return r;
  endfunction

  // Mostly events on all channels, plus chord changes, ticks and clears; every field fully
  // random underneath so each bit toggles. Some status bytes are arbitrary.
  function automatic req_t random_request();
    req_t r;
    int   pick;
    r.in_channel  = 4'($urandom_range(15));
    r.in_data1    = 7'($urandom_range(127));
    r.in_data2    = 7'($urandom_range(127));
    r.chord_root  = 4'($urandom_range(15));
    r.chord_minor = 1'($urandom_range(1));
    pick = $urandom_range(99);
    if (pick < 45)      r.in_type = NOTE_ON;
    else if (pick < 75) r.in_type = NOTE_OFF;
    else                r.in_type = 8'($urandom_range(255));
    pick = $urandom_range(99);
    if (pick < 52)      r.command = CMD_EVENT;
    else if (pick < 70) r.command = CMD_CHORD;
    else if (pick < 93) r.command = CMD_TICK;
    else                r.command = CMD_CLEAR;
    return r;
  endfunction

  // hold valid until taken; gaps only between requests
  task automatic send_req(req_t r);
    while ($urandom_range(99) < snd_idle) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= r;
    do @(posedge clk); while (!req_ready);
  endtask

  // drain every expected result, then let a silent request finish too
  task automatic settle();
    req_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_style(logic minor);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= STYLE_ADDR;
    pwdata  <= {31'($urandom), minor};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin
    rst       = 1'b1;
    req_valid = 1'b0;
    req       = '0;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    snd_idle  = 12;
    rcv_idle  = 61;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // ---- directed, major style ----
    write_style(1'b0);
    send_req(make_req(CMD_EVENT, 4'd0, NOTE_ON, 7'd0, 7'd127, 4'sd0, 1'b0));
    send_req(make_req(CMD_EVENT, 4'd1, NOTE_ON, 7'd127, 7'd0, 4'sd0, 1'b0));
    // most negative root, minor chord: accepted even though out of musical range
    send_req(make_req(CMD_CHORD, 4'd0, 8'd0, 7'd0, 7'd0, -4'sd8, 1'b1));
    // third degree lowered and clamped at zero
    send_req(make_req(CMD_EVENT, 4'd2, NOTE_ON, 7'd4, 7'd1, 4'sd0, 1'b0));
    send_req(make_req(CMD_EVENT, 4'd3, NOTE_ON, 7'd127, 7'd64, 4'sd0, 1'b0));
    send_req(make_req(CMD_CHORD, 4'd0, 8'd0, 7'd0, 7'd0, 4'sd7, 1'b0));
    // clamps at the top
    send_req(make_req(CMD_EVENT, 4'd4, NOTE_ON, 7'd125, 7'd100, 4'sd0, 1'b0));
    // drum channels pass through untouched and are not tracked
    send_req(make_req(CMD_EVENT, 4'd9, NOTE_ON, 7'd60, 7'd90, 4'sd0, 1'b0));
    send_req(make_req(CMD_EVENT, 4'd10, NOTE_OFF, 7'd60, 7'd0, 4'sd0, 1'b0));
    // non-note status passes through
    send_req(make_req(CMD_EVENT, 4'd5, CTRL_CHANGE, 7'd7, 7'd127, 4'sd0, 1'b0));
    send_req(make_req(CMD_EVENT, 4'd6, NOTE_ON, 7'd64, 7'd33, 4'sd0, 1'b0));
    send_req(make_req(CMD_EVENT, 4'd6, NOTE_OFF, 7'd64, 7'd0, 4'sd0, 1'b0));
    // tick with change pending re-sends held notes; second tick is silent
    send_req(make_req(CMD_TICK, 4'd0, 8'd0, 7'd0, 7'd0, 4'sd0, 1'b0));
    send_req(make_req(CMD_TICK, 4'd0, 8'd0, 7'd0, 7'd0, 4'sd0, 1'b0));
    // keep-chord root is ignored, so the tick stays silent
    send_req(make_req(CMD_CHORD, 4'd0, 8'd0, 7'd0, 7'd0, ROOT_KEEP, 1'b1));
    send_req(make_req(CMD_TICK, 4'd0, 8'd0, 7'd0, 7'd0, 4'sd0, 1'b0));
    send_req(make_req(CMD_CHORD, 4'd0, 8'd0, 7'd0, 7'd0, -4'sd7, 1'b1));
    send_req(make_req(CMD_TICK, 4'd0, 8'd0, 7'd0, 7'd0, 4'sd0, 1'b0));
    send_req(make_req(CMD_CLEAR, 4'd0, 8'd0, 7'd0, 7'd0, 4'sd0, 1'b0));
    send_req(make_req(CMD_EVENT, 4'd15, 8'hFF, 7'd127, 7'd127, 4'sd0, 1'b0));
    settle();

    // ---- directed, minor style: degrees raised under a major chord ----
    write_style(1'b1);
    send_req(make_req(CMD_CHORD, 4'd0, 8'd0, 7'd0, 7'd0, 4'sd0, 1'b0));
    send_req(make_req(CMD_EVENT, 4'd15, NOTE_ON, 7'd3, 7'd50, 4'sd0, 1'b0));
    send_req(make_req(CMD_EVENT, 4'd11, NOTE_ON, 7'd10, 7'd127, 4'sd0, 1'b0));
    send_req(make_req(CMD_EVENT, 4'd7, NOTE_ON, 7'd8, 7'd0, 4'sd0, 1'b0));
    send_req(make_req(CMD_TICK, 4'd0, 8'd0, 7'd0, 7'd0, 4'sd0, 1'b0));
    settle();

    // ---- random phases: receiver-heavy idle, sender-heavy idle, none ----
    for (int phase = 0; phase < 3; phase++) begin
      write_style(phase[0]);
      snd_idle  = (phase == 0) ? 12 : (phase == 1) ? 61 : 0;
      rcv_idle <= (phase == 0) ? 61 : (phase == 1) ? 12 : 0;
      for (int n = 0; n < RANDOM_PER_PHASE; n++) send_req(random_request());
      settle();
    end

    $display("Ran %0d requests and checked %0d results under both style settings,",
             requests_seen, results_seen);
    $display("with sender idling, receiver stalling and back-to-back traffic.");
    if (errors == 0 && pending == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
